// ===== sv/spectral_raised_cosine_mask_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the spectral raised-cosine mask
// Shared concurrent check forms, clocked on clk_i and idle in reset.
// ----------------------------------------------------------------------------
`ifndef SPECTRAL_RAISED_COSINE_MASK_ASSERT_SVH
`define SPECTRAL_RAISED_COSINE_MASK_ASSERT_SVH

// The property must hold at every clock edge out of reset.
`define SRCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// The condition must never be true out of reset.
`define SRCM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== sv/srcm_pkg.sv =====
// ----------------------------------------------------------------------------
// Spectral raised-cosine mask package
// Types, register indexes, sizes and the raised-cosine table.
// ----------------------------------------------------------------------------
package srcm_pkg;

  localparam int BINS_DEFAULT  = 512;
  localparam int QUEUE_DEPTH   = 4;
  localparam int BIN_W         = 9;
  localparam int DATA_W        = 16;
  localparam int PH_W          = 11;
  localparam int AN_W          = 16;
  // Dividend is |numerator| scaled by 1024.
  localparam int NUM_W         = AN_W + 10;
  localparam int CFG_ADDR_W    = 3;

  localparam logic [PH_W-1:0]   PH_ONE   = 11'd1024;
  localparam logic [DATA_W-1:0] GAIN_ONE = 16'd32768;

  localparam logic [1:0] MODE_LOW  = 2'd0;
  localparam logic [1:0] MODE_HIGH = 2'd1;
  localparam logic [1:0] MODE_BAND = 2'd2;
  // The unused mode code behaves as band-pass.
  localparam logic [1:0] MODE_RSVD = 2'd3;

  localparam logic [CFG_ADDR_W-1:0] REG_FILTER_MODE    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TRANSFORM_KIND = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_UPPER_PASS     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_UPPER_STOP     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_LOWER_PASS     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_LOWER_STOP     = 3'd5;

  typedef enum logic [1:0] {
    CLS_PASS,
    CLS_TAPER,
    CLS_STOP
  } cls_e;

  typedef struct packed {
    logic [1:0]        filter_mode;
    logic              transform_kind;
    logic [DATA_W-1:0] upper_pass;
    logic [DATA_W-1:0] upper_stop;
    logic [DATA_W-1:0] lower_pass;
    logic [DATA_W-1:0] lower_stop;
  } cfg_t;

  // Per-edge classification that rides along with the division.
  typedef struct packed {
    cls_e cls;
    logic dz;
    logic npos;
  } side_t;

  typedef struct packed {
    logic                     oob;
    logic [1:0]               mode;
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
    side_t                    lp;
  } main_t;

  typedef struct packed {
    main_t           main;
    side_t           hp;
    logic [PH_W-1:0] lp_q;
    logic [PH_W-1:0] hp_q;
  } item_t;

  localparam logic [DATA_W-1:0] RC_TABLE [33] = '{
    16'd32768, 16'd32689, 16'd32453, 16'd32063, 16'd31521, 16'd30833, 16'd30007,
    16'd29049, 16'd27969, 16'd26778, 16'd25486, 16'd24107, 16'd22654, 16'd21140,
    16'd19580, 16'd17990, 16'd16384, 16'd14778, 16'd13188, 16'd11628, 16'd10114,
    16'd8661,  16'd7282,  16'd5990,  16'd4799,  16'd3719,  16'd2761,  16'd1935,
    16'd1247,  16'd705,   16'd315,   16'd79,    16'd0
  };

  // (1 + cos(pi*ph/1024)) / 2 in Q1.15 with linear interpolation.
  function automatic logic [DATA_W-1:0] rc_lookup(input logic [PH_W-1:0] ph);
    logic [5:0]        idx;
    logic [4:0]        fr;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] prod;
    if (ph >= PH_ONE) begin
      return '0;
    end
    idx  = {1'b0, ph[9:5]};
    fr   = ph[4:0];
    a    = RC_TABLE[idx];
    b    = RC_TABLE[idx + 6'd1];
    prod = (a - b) * DATA_W'(fr) + 16'd16;
    return a - (prod >> 5);
  endfunction

endpackage

// ===== sv/srcm_front.sv =====
// ----------------------------------------------------------------------------
// Mask front end
// Mirrors the bin in FFT mode, finds the band edges and classifies the bin for each edge.
// ----------------------------------------------------------------------------
module srcm_front import srcm_pkg::*; #(
  parameter int Bins = BINS_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [BIN_W-1:0]         bin_index_i,
  input  logic signed [DATA_W-1:0] re_i,
  input  logic signed [DATA_W-1:0] im_i,
  input  cfg_t                     cfg_i,
  output logic                     valid_o,
  output main_t                    main_o,
  output side_t                    hp_o,
  output logic [AN_W-1:0]          lp_an_o,
  output logic [AN_W-1:0]          hp_an_o,
  output logic [DATA_W-1:0]        lp_den_o,
  output logic [DATA_W-1:0]        hp_den_o
);

  localparam int LB     = $clog2(Bins);
  localparam int MW     = LB + 1;
  localparam int KW     = (MW > BIN_W) ? MW : BIN_W;
  localparam int ShMclt = 15 - LB;
  localparam int ShFft  = 16 - LB;
  localparam logic [16:0] RndMclt = 17'd1 << (ShMclt - 1);
  localparam logic [16:0] RndFft  = 17'd1 << (ShFft - 1);
  localparam logic [16:0] LimMclt = 17'(Bins - 1);
  localparam logic [16:0] LimFft  = 17'(Bins / 2);

  function automatic logic [16:0] lo_edge(input logic [DATA_W-1:0] f, input logic fft);
    logic [16:0] v;
    v = fft ? 17'(f >> ShFft) : 17'(f >> ShMclt);
    if (v == '0) begin
      v = 17'd1;
    end
    return v;
  endfunction

  function automatic logic [16:0] hi_edge(input logic [DATA_W-1:0] f, input logic fft);
    logic [16:0] v;
    logic [16:0] lim;
    v   = fft ? (({1'b0, f} + RndFft) >> ShFft) : (({1'b0, f} + RndMclt) >> ShMclt);
    lim = fft ? LimFft : LimMclt;
    return (v > lim) ? lim : v;
  endfunction

  // Numerator m*2^16/S (FFT) or m*2^15/S (MCLT) - from, returned as positive flag and magnitude.
  function automatic logic [AN_W:0] num_mag(input logic [16:0] msh,
                                            input logic [DATA_W-1:0] from);
    logic signed [17:0] n;
    n = $signed({1'b0, msh}) - $signed({2'b0, from});
    return {(n > 18'sd0), (n < 18'sd0) ? AN_W'(-n) : AN_W'(n)};
  endfunction

  logic [KW-1:0]     k_ext;
  logic [KW-1:0]     m_k;
  logic [16:0]       m17;
  logic [16:0]       msh;
  logic              fft;
  logic [16:0]       lp_lo, lp_hi, hp_lo, hp_hi;
  logic [AN_W:0]     lp_nm, hp_nm;
  main_t             main_d;
  side_t             hp_d;
  logic              valid_q;
  main_t             main_q;
  side_t             hp_q;
  logic [AN_W-1:0]   lp_an_q, hp_an_q;

  always_comb begin
    fft   = cfg_i.transform_kind;
    k_ext = KW'(bin_index_i);
    m_k   = (fft && (k_ext > KW'(Bins / 2))) ? (KW'(Bins) - k_ext) : k_ext;
    m17   = 17'(m_k);
    msh   = fft ? (m17 << ShFft) : (m17 << ShMclt);
    lp_lo = lo_edge(cfg_i.upper_pass, fft);
    lp_hi = hi_edge(cfg_i.upper_stop, fft);
    hp_lo = lo_edge(cfg_i.lower_stop, fft);
    hp_hi = hi_edge(cfg_i.lower_pass, fft);
    lp_nm = num_mag(msh, cfg_i.upper_pass);
    hp_nm = num_mag(msh, cfg_i.lower_stop);

    main_d.oob     = (k_ext >= KW'(Bins));
    main_d.mode    = cfg_i.filter_mode;
    main_d.re      = re_i;
    main_d.im      = im_i;
    main_d.lp.npos = lp_nm[AN_W];
    main_d.lp.dz   = (lp_den_o == '0);
    if (m17 < lp_lo) begin
      main_d.lp.cls = CLS_PASS;
    end else if (m17 <= lp_hi) begin
      main_d.lp.cls = CLS_TAPER;
    end else begin
      main_d.lp.cls = CLS_STOP;
    end

    hp_d.npos = hp_nm[AN_W];
    hp_d.dz   = (hp_den_o == '0);
    if (m17 < hp_lo) begin
      hp_d.cls = CLS_STOP;
    end else if (m17 <= hp_hi) begin
      hp_d.cls = CLS_TAPER;
    end else begin
      hp_d.cls = CLS_PASS;
    end
  end

  // Change edge spans only while the block is idle (unchecked); they feed the dividers live.
  assign lp_den_o = (cfg_i.upper_stop >= cfg_i.upper_pass) ?
                    (cfg_i.upper_stop - cfg_i.upper_pass) : (cfg_i.upper_pass - cfg_i.upper_stop);
  assign hp_den_o = (cfg_i.lower_pass >= cfg_i.lower_stop) ?
                    (cfg_i.lower_pass - cfg_i.lower_stop) : (cfg_i.lower_stop - cfg_i.lower_pass);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      main_q  <= main_d;
      hp_q    <= hp_d;
      lp_an_q <= lp_nm[AN_W-1:0];
      hp_an_q <= hp_nm[AN_W-1:0];
    end
  end

  assign valid_o = valid_q;
  assign main_o  = main_q;
  assign hp_o    = hp_q;
  assign lp_an_o = lp_an_q;
  assign hp_an_o = hp_an_q;

endmodule

// ===== sv/srcm_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage; keeps the low quotient bits and a side payload.
// ----------------------------------------------------------------------------
module srcm_div import srcm_pkg::*; #(
  parameter int NumW = NUM_W,
  parameter int DenW = DATA_W,
  parameter int QuoW = PH_W,
  parameter int PayW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  input  logic [PayW-1:0] pay_i,
  output logic            valid_o,
  output logic [QuoW-1:0] quo_o,
  output logic [PayW-1:0] pay_o
);

  logic            vld_q  [NumW];
  logic [DenW-1:0] rem_q  [NumW];
  logic [NumW-1:0] num_q  [NumW];
  logic [QuoW-1:0] quo_q  [NumW];
  logic [PayW-1:0] pay_q  [NumW];

  logic [DenW-1:0] src_rem [NumW];
  logic [NumW-1:0] src_num [NumW];
  logic [QuoW-1:0] src_quo [NumW];
  logic [DenW:0]   trial   [NumW];
  logic            ge      [NumW];
  logic [DenW-1:0] rem_d   [NumW];
  logic [NumW-1:0] num_d   [NumW];
  logic [QuoW-1:0] quo_d   [NumW];

  always_comb begin
    src_rem[0] = '0;
    src_num[0] = num_i;
    src_quo[0] = '0;
    for (int i = 1; i < NumW; i++) begin
      src_rem[i] = rem_q[i-1];
      src_num[i] = num_q[i-1];
      src_quo[i] = quo_q[i-1];
    end
    for (int i = 0; i < NumW; i++) begin
      trial[i] = {src_rem[i], src_num[i][NumW-1]};
      ge[i]    = (trial[i] >= {1'b0, den_i});
      rem_d[i] = ge[i] ? DenW'(trial[i] - {1'b0, den_i}) : trial[i][DenW-1:0];
      num_d[i] = src_num[i] << 1;
      quo_d[i] = {src_quo[i][QuoW-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumW; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int i = 1; i < NumW; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pay_q[0] <= pay_i;
      for (int i = 1; i < NumW; i++) begin
        pay_q[i] <= pay_q[i-1];
      end
      for (int i = 0; i < NumW; i++) begin
        rem_q[i] <= rem_d[i];
        num_q[i] <= num_d[i];
        quo_q[i] <= quo_d[i];
      end
    end
  end

  assign valid_o = vld_q[NumW-1];
  assign quo_o   = quo_q[NumW-1];
  assign pay_o   = pay_q[NumW-1];

endmodule

// ===== sv/srcm_queue.sv =====
// ----------------------------------------------------------------------------
// Mask request queue
// Small first-in first-out buffer between the divider pipeline and the back end.
// ----------------------------------------------------------------------------
module srcm_queue import srcm_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output item_t item_o,
  output logic  empty_o,
  output logic  full_o
);

  `include "spectral_raised_cosine_mask_assert.svh"

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  item_t           entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(Depth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

  `SRCM_ASSERT_NEVER(a_queue_overflow, push_i && full_o, "request pushed into a full queue")
  `SRCM_ASSERT_NEVER(a_queue_underflow, pop_i && empty_o, "request popped from an empty queue")
  `SRCM_ASSERT(a_count_step, do_push && !do_pop |=> count_q == $past(count_q) + 1'b1, "queue count lost a request")

endmodule

// ===== sv/srcm_back.sv =====
// ----------------------------------------------------------------------------
// Mask back end
// Turns phases into tapers, combines the gains and scales the bin.
// ----------------------------------------------------------------------------
module srcm_back import srcm_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  item_t                    item_i,
  input  logic                     avail_i,
  output logic                     pop_o,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic signed [DATA_W-1:0] re_o,
  output logic signed [DATA_W-1:0] im_o,
  output logic [DATA_W-1:0]        gain_o
);

  `include "spectral_raised_cosine_mask_assert.svh"

  function automatic logic [PH_W-1:0] fold(input logic [PH_W-1:0] q, input side_t sd);
    if (sd.dz) begin
      return sd.npos ? PH_ONE : '0;
    end
    if (q > PH_ONE) begin
      return PH_W'(12'd2048 - {1'b0, q});
    end
    return q;
  endfunction

  logic                     en;
  logic [DATA_W-1:0]        lp_rc, hp_rc, lp_g, hp_g;
  logic [31:0]              bp_prod;
  logic [DATA_W-1:0]        g_d;
  logic signed [32:0]       p_re, p_im;

  logic                     s1_vld_q;
  logic                     s1_oob_q;
  logic [1:0]               s1_mode_q;
  logic signed [DATA_W-1:0] s1_re_q, s1_im_q;
  logic [DATA_W-1:0]        s1_lp_q, s1_hp_q;
  logic                     s2_vld_q;
  logic signed [DATA_W-1:0] s2_re_q, s2_im_q;
  logic [DATA_W-1:0]        s2_g_q;
  logic                     out_vld_q;
  logic signed [DATA_W-1:0] out_re_q, out_im_q;
  logic [DATA_W-1:0]        out_g_q;

  assign en    = !out_vld_q || ready_i;
  assign pop_o = en && avail_i;

  always_comb begin
    lp_rc = rc_lookup(fold(item_i.lp_q, item_i.main.lp));
    hp_rc = rc_lookup(fold(item_i.hp_q, item_i.hp));
    case (item_i.main.lp.cls)
      CLS_PASS:  lp_g = GAIN_ONE;
      CLS_TAPER: lp_g = lp_rc;
      default:   lp_g = '0;
    endcase
    case (item_i.hp.cls)
      CLS_STOP:  hp_g = '0;
      CLS_TAPER: hp_g = GAIN_ONE - hp_rc;
      default:   hp_g = GAIN_ONE;
    endcase
  end

  always_comb begin
    bp_prod = 32'(s1_lp_q) * 32'(s1_hp_q) + 32'd16384;
    if (s1_oob_q) begin
      g_d = '0;
    end else begin
      case (s1_mode_q)
        MODE_LOW:  g_d = s1_lp_q;
        MODE_HIGH: g_d = s1_hp_q;
        default:   g_d = bp_prod[30:15];
      endcase
    end
  end

  always_comb begin
    p_re = ($signed(s2_re_q) * $signed({1'b0, s2_g_q})) + 33'sd16384;
    p_im = ($signed(s2_im_q) * $signed({1'b0, s2_g_q})) + 33'sd16384;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= avail_i;
      s2_vld_q  <= s1_vld_q;
      out_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_oob_q  <= item_i.main.oob;
      s1_mode_q <= item_i.main.mode;
      s1_re_q   <= item_i.main.re;
      s1_im_q   <= item_i.main.im;
      s1_lp_q   <= lp_g;
      s1_hp_q   <= hp_g;
      s2_re_q   <= s1_re_q;
      s2_im_q   <= s1_im_q;
      s2_g_q    <= g_d;
      out_re_q  <= p_re[30:15];
      out_im_q  <= p_im[30:15];
      out_g_q   <= s2_g_q;
    end
  end

  assign valid_o = out_vld_q;
  assign re_o    = out_re_q;
  assign im_o    = out_im_q;
  assign gain_o  = out_g_q;

  `SRCM_ASSERT_NEVER(a_gain_range, out_vld_q && (out_g_q > GAIN_ONE), "gain above unity")
  `SRCM_ASSERT(a_zero_gain, en && s2_vld_q && (s2_g_q == '0) |=> (out_re_q == '0) && (out_im_q == '0), "zero gain left a nonzero bin")

endmodule

// ===== sv/spectral_raised_cosine_mask.sv =====
// ----------------------------------------------------------------------------
// Spectral raised-cosine mask
// Low-, high- or band-pass gain with raised-cosine tapers on spectrum bins.
// ----------------------------------------------------------------------------
// Usage: bins enter on the s_axis channel (tdata bits: bin_index, re_in,
// im_in) and leave on m_axis (re_out, im_out, gain), one result per bin, in
// order. Registers are written on the cfg channel, which is always ready;
// write them only while no bin is in flight.
// Throughput is one bin per cycle while the queue has room. From input
// request to output request a bin passes one front stage, 26 stages of
// the two parallel one-bit-per-stage dividers that form the taper phase,
// the queue and three back stages (table taper, gain product, bin scaling
// with output register).
// A four-entry queue separates the divider pipeline from the back end; when
// the receiver stalls the back end holds its output, the queue fills and
// then s_axis_tready drops until space frees up.
// Reset empties all stages and the queue and loads the register defaults.
// Bins must be a power of two.
// ----------------------------------------------------------------------------
module spectral_raised_cosine_mask import srcm_pkg::*; #(
  parameter int Bins       = BINS_DEFAULT,
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [8:0] bin_index, [24:9] re_in, [40:25] im_in, [47:41] zero
  input  logic [47:0]           s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [15:0] re_out, [31:16] im_out, [47:32] gain
  output logic [47:0]           m_axis_tdata,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [DATA_W-1:0]     cfg_data_i
);

  localparam int MainW = $bits(main_t);
  localparam int SideW = $bits(side_t);

  cfg_t              cfg_q;
  logic              en_pipe;
  logic              f_valid;
  main_t             f_main;
  side_t             f_hp;
  logic [AN_W-1:0]   f_lp_an, f_hp_an;
  logic [DATA_W-1:0] lp_den, hp_den;
  logic              lp_valid, hp_valid;
  logic [PH_W-1:0]   lp_quo, hp_quo;
  logic [MainW-1:0]  lp_pay;
  logic [SideW-1:0]  hp_pay;
  item_t             q_in, q_out;
  logic              q_empty, q_full, q_pop;
  logic signed [DATA_W-1:0] re_out, im_out;
  logic [DATA_W-1:0] gain_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.filter_mode    <= MODE_LOW;
      cfg_q.transform_kind <= 1'b0;
      cfg_q.upper_pass     <= 16'd8192;
      cfg_q.upper_stop     <= 16'd12288;
      cfg_q.lower_pass     <= 16'd4096;
      cfg_q.lower_stop     <= 16'd2048;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_FILTER_MODE:    cfg_q.filter_mode    <= cfg_data_i[1:0];
        REG_TRANSFORM_KIND: cfg_q.transform_kind <= cfg_data_i[0];
        REG_UPPER_PASS:     cfg_q.upper_pass     <= cfg_data_i;
        REG_UPPER_STOP:     cfg_q.upper_stop     <= cfg_data_i;
        REG_LOWER_PASS:     cfg_q.lower_pass     <= cfg_data_i;
        REG_LOWER_STOP:     cfg_q.lower_stop     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The front end and dividers move together and freeze only when the queue is full.
  assign en_pipe       = !q_full;
  assign s_axis_tready = en_pipe;

  srcm_front #(
    .Bins(Bins)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en_pipe),
    .valid_i    (s_axis_tvalid),
    .bin_index_i(s_axis_tdata[8:0]),
    .re_i       (s_axis_tdata[24:9]),
    .im_i       (s_axis_tdata[40:25]),
    .cfg_i      (cfg_q),
    .valid_o    (f_valid),
    .main_o     (f_main),
    .hp_o       (f_hp),
    .lp_an_o    (f_lp_an),
    .hp_an_o    (f_hp_an),
    .lp_den_o   (lp_den),
    .hp_den_o   (hp_den)
  );

  srcm_div #(
    .NumW(NUM_W),
    .DenW(DATA_W),
    .QuoW(PH_W),
    .PayW(MainW)
  ) u_div_lp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_pipe),
    .valid_i(f_valid),
    .num_i  ({f_lp_an, 10'd0}),
    .den_i  (lp_den),
    .pay_i  (f_main),
    .valid_o(lp_valid),
    .quo_o  (lp_quo),
    .pay_o  (lp_pay)
  );

  srcm_div #(
    .NumW(NUM_W),
    .DenW(DATA_W),
    .QuoW(PH_W),
    .PayW(SideW)
  ) u_div_hp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_pipe),
    .valid_i(f_valid),
    .num_i  ({f_hp_an, 10'd0}),
    .den_i  (hp_den),
    .pay_i  (f_hp),
    .valid_o(hp_valid),
    .quo_o  (hp_quo),
    .pay_o  (hp_pay)
  );

  always_comb begin
    q_in.main = main_t'(lp_pay);
    q_in.hp   = side_t'(hp_pay);
    q_in.lp_q = lp_quo;
    q_in.hp_q = hp_quo;
  end

  srcm_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (en_pipe && lp_valid),
    .item_i (q_in),
    .pop_i  (q_pop),
    .item_o (q_out),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  srcm_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (q_out),
    .avail_i(!q_empty),
    .pop_o  (q_pop),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .re_o   (re_out),
    .im_o   (im_out),
    .gain_o (gain_out)
  );

  assign m_axis_tdata = {gain_out, im_out, re_out};

  `include "spectral_raised_cosine_mask_assert.svh"

  `SRCM_ASSERT_NEVER(a_div_aligned, lp_valid != hp_valid, "divider pipelines out of step")

endmodule
